// ===== src/bsl_pkg.sv =====
// Shared types, codes and defaults for the bounded sequence list.
`default_nettype none
package bsl_pkg;

    // Default list depth
    localparam int DEPTH_DEF = 16;

    // Operation codes
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    // Input item
    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               has_element;
        logic [4:0]         count;
        logic               last;
    } t_out_item;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load_back;
        logic rotate;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== src/bsl_cell.sv =====
// One storage cell of the list chain; trades its entry with its neighbors.
`default_nettype none
module bsl_cell #(
    parameter int DEPTH = bsl_pkg::DEPTH_DEF,
    parameter int IDX   = 0,
    parameter int LW    = $clog2(DEPTH + 1)
) (
    input  wire logic                i_clk,
    input  wire bsl_pkg::t_cell_ctl  i_ctl,
    input  wire logic [LW-1:0]       i_len,
    input  wire logic signed [31:0]  i_value,
    input  wire logic signed [31:0]  i_left,
    input  wire logic signed [31:0]  i_right,
    input  wire logic signed [31:0]  i_head,
    output logic signed [31:0]       o_entry
);

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;
    logic               w_at_len;
    logic               w_is_tail;

    assign w_at_len  = (i_len == LW'(IDX));
    assign w_is_tail = ((i_len - 1'b1) == LW'(IDX));

    // Next entry: shift up/down, back load, or rotate toward the front
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_up) begin
            n_entry = (IDX == 0) ? i_value : i_left;
        end else if (i_ctl.shift_down) begin
            n_entry = i_right;
        end else if (i_ctl.load_back) begin
            if (w_at_len) begin
                n_entry = i_value;
            end
        end else if (i_ctl.rotate) begin
            n_entry = w_is_tail ? i_head : i_right;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

// ===== src/bounded_sequence_list_unit.sv =====
// An update item gives its status result in the output register in the cycle after accept.
// Throughput: one update item per cycle while the output side does not stall.
// A dump of L entries gives L results, one per cycle while the output side does not stall,
// by rotating the cell chain L places; the next item is taken once the controller is back in idle.
// Reset clears the length, the controller and the output valid; cell entries are not reset.
`default_nettype none
module bounded_sequence_list_unit #(
    parameter int DEPTH = bsl_pkg::DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire bsl_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output bsl_pkg::t_out_item      o_out_item
);

    localparam int LW = $clog2(DEPTH + 1);

    bsl_pkg::t_state    r_state;
    bsl_pkg::t_state    n_state;
    logic [LW-1:0]      r_len;
    logic [LW-1:0]      n_len;
    logic [LW-1:0]      r_idx;
    logic [LW-1:0]      n_idx;
    logic               r_out_valid;
    bsl_pkg::t_out_item r_out;
    bsl_pkg::t_out_item n_out;
    logic               w_load_out;
    bsl_pkg::t_cell_ctl w_ctl;
    logic               w_accept;
    logic               w_out_free;
    logic               w_full;
    logic               w_empty;
    logic               w_dump_end;
    logic [LW+4:0]      w_cnt_ext;
    logic signed [31:0] w_entry [DEPTH];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != bsl_pkg::S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_len == LW'(DEPTH));
    assign w_empty    = (r_len == '0);
    assign w_dump_end = (r_idx == (r_len - 1'b1));
    assign w_cnt_ext  = {5'b0, n_len};

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_lastc
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        bsl_cell #(
            .DEPTH (DEPTH),
            .IDX   (g),
            .LW    (LW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_len   (r_len),
            .i_value (i_in_item.value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_entry[0]),
            .o_entry (w_entry[g])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsl_pkg::S_IDLE: begin
                if (w_accept && (i_in_item.opcode == bsl_pkg::OP_DUMP) && !w_empty) begin
                    n_state = bsl_pkg::S_DUMP;
                end
            end
            bsl_pkg::S_DUMP: begin
                if (w_out_free && w_dump_end) begin
                    n_state = bsl_pkg::S_IDLE;
                end
            end
            default: n_state = bsl_pkg::S_IDLE;
        endcase
    end

    // Cell commands, length, dump index and result item
    always_comb begin
        w_ctl       = '0;
        n_len       = r_len;
        n_idx       = r_idx;
        w_load_out  = 1'b0;
        n_out.status      = bsl_pkg::ST_OK;
        n_out.element     = '0;
        n_out.has_element = 1'b0;
        n_out.last        = 1'b1;
        case (r_state)
            bsl_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_load_out = 1'b1;
                    case (i_in_item.opcode)
                        bsl_pkg::OP_PUSH_BACK: begin
                            if (w_full) begin
                                n_out.status = bsl_pkg::ST_FULL;
                            end else begin
                                w_ctl.load_back = 1'b1;
                                n_len = r_len + 1'b1;
                            end
                        end
                        bsl_pkg::OP_PUSH_FRONT: begin
                            if (w_full) begin
                                n_out.status = bsl_pkg::ST_FULL;
                            end else begin
                                w_ctl.shift_up = 1'b1;
                                n_len = r_len + 1'b1;
                            end
                        end
                        bsl_pkg::OP_POP_BACK: begin
                            if (w_empty) begin
                                n_out.status = bsl_pkg::ST_EMPTY;
                            end else begin
                                n_len = r_len - 1'b1;
                            end
                        end
                        bsl_pkg::OP_POP_FRONT: begin
                            if (w_empty) begin
                                n_out.status = bsl_pkg::ST_EMPTY;
                            end else begin
                                w_ctl.shift_down = 1'b1;
                                n_len = r_len - 1'b1;
                            end
                        end
                        bsl_pkg::OP_DUMP: begin
                            if (w_empty) begin
                                n_out.status = bsl_pkg::ST_EMPTY;
                            end else begin
                                w_load_out = 1'b0;
                                n_idx = '0;
                            end
                        end
                        default: begin
                            n_out.status = bsl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bsl_pkg::S_DUMP: begin
                if (w_out_free) begin
                    w_ctl.rotate      = 1'b1;
                    w_load_out        = 1'b1;
                    n_out.element     = w_entry[0];
                    n_out.has_element = 1'b1;
                    n_out.last        = w_dump_end;
                    n_idx             = r_idx + 1'b1;
                end
            end
            default: begin
                w_load_out = 1'b0;
            end
        endcase
        // count keeps the low five bits of the length
        n_out.count = w_cnt_ext[4:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsl_pkg::S_IDLE;
            r_len       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_idx   <= n_idx;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// ===== src/bsl_checker.sv =====
// Port-level checks for the bounded sequence list, bound to the top level.
`default_nettype none
module bsl_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire bsl_pkg::t_in_item  i_in_item,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire bsl_pkg::t_out_item o_out_item
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // No item enters while a dump still has entries to give
    a_dump_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.has_element && !o_out_item.last |-> o_in_stall)
        else $error("input taken during dump");

    // Results without an entry are single and carry a zero element
    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.has_element |->
            o_out_item.last && (o_out_item.element == 32'sd0))
        else $error("bad plain result");

    // Dump results always report ok
    a_dump_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.has_element |-> o_out_item.status == bsl_pkg::ST_OK)
        else $error("dump result with error status");

    // Reset empties the output
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind bounded_sequence_list_unit bsl_checker u_bsl_checker (.*);
`default_nettype wire
